FILE: design/csenv_pkg.sv
// Shared types and constants for the cycling slew envelope unit.
package csenv_pkg;

	localparam int LVL_W  = 16;
	localparam int COEF_W = 17;
	localparam int DEP_W  = 15;
	localparam int IDX_W  = 3;

	localparam logic signed [LVL_W-1:0] LVL_ONE  = 16'sd16384;
	localparam logic signed [LVL_W-1:0] LVL_MONE = -16'sd16384;
	localparam logic signed [LVL_W:0]   SNAP_HI  = 17'sd16368;
	localparam logic signed [LVL_W:0]   SNAP_LO  = -17'sd16368;
	localparam logic [COEF_W-1:0]       COEF_ONE = 17'd65536;
	localparam logic [DEP_W-1:0]        DEP_ONE  = 15'd16384;

	localparam logic [IDX_W-1:0] CFG_RISE  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_FALL  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_DEPTH = 3'd2;
	localparam logic [IDX_W-1:0] CFG_CYCLE = 3'd3;
	localparam logic [IDX_W-1:0] CFG_FROZE = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RISE,
		PH_FALL
	} phase_t;

	typedef enum logic [2:0] {
		SQ_WAIT,
		SQ_PREP,
		SQ_MUL,
		SQ_UPD,
		SQ_SCALE,
		SQ_DONE
	} seq_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] target;
		logic                    trigger;
	} item_t;

	typedef struct packed {
		logic [COEF_W-1:0] rise;
		logic [COEF_W-1:0] fall;
		logic [DEP_W-1:0]  depth;
		logic              cycle_mode;
		logic              frozen;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: design/csenv_front.sv
// Input side: accepts stream words and clamps the target to plus or minus one.
module csenv_front import csenv_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] target_level
	input  logic [0:0]  s_tuser,   // [0] trigger
	input  q_stat_t     q_stat,
	output logic        push,
	output item_t       push_item
);

	logic signed [LVL_W-1:0] raw;

	assign raw      = $signed(s_tdata[LVL_W-1:0]);
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	always_comb begin
		push_item.trigger = s_tuser[0];
		if (raw > LVL_ONE) begin
			push_item.target = LVL_ONE;
		end else if (raw < LVL_MONE) begin
			push_item.target = LVL_MONE;
		end else begin
			push_item.target = raw;
		end
	end

endmodule

FILE: design/csenv_queue.sv
// Short word queue between the input side and the envelope sequencer.
module csenv_queue import csenv_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/csenv_back.sv
// Envelope sequencer: lag step, stage logic, depth scaling and output register.
module csenv_back import csenv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_stat_t     q_stat,
	input  item_t       head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] cv_out
	output logic [1:0]  m_tuser    // [0] end_of_rise, [1] end_of_cycle
);

	seq_t state_q, state_d;

	logic signed [LVL_W-1:0] level_q;
	phase_t                  phase_q;
	logic                    pending_q;

	// prep stage
	logic                    pend;
	logic signed [LVL_W-1:0] lvl;
	phase_t                  ph;
	logic signed [LVL_W-1:0] goal;
	logic [COEF_W-1:0]       k;
	logic signed [LVL_W:0]   diff;
	logic [LVL_W:0]          diff_abs;
	logic [LVL_W-1:0]        mag;

	logic signed [LVL_W-1:0] cur_s1;
	phase_t                  ph_s1;
	logic                    neg_s1;
	logic [LVL_W-1:0]        mag_s1;
	logic [COEF_W-1:0]       k_s1;
	logic                    frz_s1;
	logic                    pend_s1;

	logic [31:0]             prod_s2;

	// update stage
	logic [31:0]             rsum;
	logic [LVL_W-1:0]        step;
	logic signed [LVL_W:0]   nxt;
	logic signed [LVL_W-1:0] lvl_new;
	phase_t                  ph_new;
	logic                    eor_new;
	logic                    eoc_new;
	logic                    eor_s3;
	logic                    eoc_s3;

	logic signed [31:0]      scl_s4;
	logic [31:0]             scl_abs;
	logic [31:0]             rnd;
	logic [LVL_W-1:0]        cv;

	logic                    out_valid_q;
	logic [LVL_W-1:0]        out_cv_q;
	logic [1:0]              out_flag_q;
	logic                    wr_out;

	assign pop      = (state_q == SQ_PREP);
	assign wr_out   = (state_q == SQ_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_cv_q;
	assign m_tuser  = out_flag_q;

	// Apply a pending trigger and cycle mode, then pick goal and coefficient.
	always_comb begin
		pend = pending_q | head.trigger;
		lvl  = level_q;
		ph   = phase_q;
		if (!cfg.frozen) begin
			if (pend) begin
				lvl = LVL_MONE;
				ph  = PH_RISE;
			end
			if (cfg.cycle_mode && ph == PH_IDLE) begin
				ph = PH_RISE;
			end
		end
		case (ph)
			PH_IDLE: begin
				goal = head.target;
				k    = (head.target >= lvl) ? cfg.rise : cfg.fall;
			end
			PH_RISE: begin
				goal = LVL_ONE;
				k    = cfg.rise;
			end
			default: begin
				goal = LVL_MONE;
				k    = cfg.fall;
			end
		endcase
		diff     = {goal[LVL_W-1], goal} - {lvl[LVL_W-1], lvl};
		diff_abs = diff[LVL_W] ? (LVL_W+1)'(0) - diff : diff;
		mag      = cfg.frozen ? '0 : diff_abs[LVL_W-1:0];
	end

	// Round the step up, move the level and check the stage ends.
	always_comb begin
		rsum    = prod_s2 + 32'd65535;
		step    = rsum[31:16];
		if (step > mag_s1) begin
			step = mag_s1;
		end
		nxt     = neg_s1 ? {cur_s1[LVL_W-1], cur_s1} - {1'b0, step}
		                 : {cur_s1[LVL_W-1], cur_s1} + {1'b0, step};
		lvl_new = nxt[LVL_W-1:0];
		ph_new  = ph_s1;
		eor_new = 1'b0;
		eoc_new = 1'b0;
		case (ph_s1)
			PH_IDLE: begin
			end
			PH_RISE: begin
				if (nxt >= SNAP_HI) begin
					lvl_new = LVL_ONE;
					ph_new  = PH_FALL;
					eor_new = 1'b1;
				end
			end
			default: begin
				if (nxt <= SNAP_LO) begin
					lvl_new = LVL_MONE;
					ph_new  = PH_IDLE;
					eoc_new = 1'b1;
				end
			end
		endcase
	end

	// Round level times depth to nearest, halves away from zero.
	always_comb begin
		scl_abs = scl_s4[31] ? 32'd0 - 32'(scl_s4) : 32'(scl_s4);
		rnd     = scl_abs + 32'd8192;
		cv      = scl_s4[31] ? LVL_W'(0) - rnd[LVL_W+13:14] : rnd[LVL_W+13:14];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_WAIT:  if (!q_stat.empty) state_d = SQ_PREP;
			SQ_PREP:  state_d = SQ_MUL;
			SQ_MUL:   state_d = SQ_UPD;
			SQ_UPD:   state_d = SQ_SCALE;
			SQ_SCALE: state_d = SQ_DONE;
			SQ_DONE: begin
				if (wr_out) begin
					state_d = q_stat.empty ? SQ_WAIT : SQ_PREP;
				end
			end
			default:  state_d = SQ_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_PREP) begin
			cur_s1  <= lvl;
			ph_s1   <= ph;
			neg_s1  <= diff[LVL_W];
			mag_s1  <= mag;
			k_s1    <= k;
			frz_s1  <= cfg.frozen;
			pend_s1 <= pend;
		end
		if (state_q == SQ_MUL) begin
			prod_s2 <= 32'({16'd0, mag_s1} * {15'd0, k_s1});
		end
		if (state_q == SQ_UPD) begin
			eor_s3 <= frz_s1 ? 1'b0 : eor_new;
			eoc_s3 <= frz_s1 ? 1'b0 : eoc_new;
		end
		if (state_q == SQ_SCALE) begin
			scl_s4 <= 32'(level_q) * 32'($signed({1'b0, cfg.depth}));
		end
		if (wr_out) begin
			out_cv_q   <= cv;
			out_flag_q <= {eoc_s3, eor_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			phase_q     <= PH_IDLE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == SQ_UPD) begin
				if (frz_s1) begin
					// hold level and stage, keep the trigger pending
					pending_q <= pend_s1;
				end else begin
					pending_q <= 1'b0;
					level_q   <= lvl_new;
					phase_q   <= ph_new;
				end
			end
			if (wr_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q <= LVL_ONE) && (level_q >= LVL_MONE))
		else $error("level left the unit range");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_flag_q[0] && out_flag_q[1]))
		else $error("both stage pulses set on one word");

	a_done_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished result not loaded into output register");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");
`endif

endmodule

FILE: design/cycling_slew_envelope_unit.sv
// Top level of the cycling slew envelope unit: config registers, front, queue, sequencer.
//
// Input words arrive on s_tvalid/s_tready: s_tdata carries the target level
// (Q2.14, clamped to plus or minus one), s_tuser[0] the trigger flag.
// Results leave on m_tvalid/m_tready: m_tdata is cv_out (level times depth,
// Q2.14), m_tuser[0] end_of_rise, m_tuser[1] end_of_cycle. One result per word.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index (0 rise
// coefficient, 1 fall coefficient, 2 depth, 3 cycle_mode, 4 frozen) and
// cfg_data; cfg_ready is always high, coefficients above one and depth above
// one (taken from the low 15 bits of cfg_data) saturate, other indexes are ignored.
// Each word passes through the sequencer steps in order (prepare, lag multiply, level
// update, depth multiply, output load), and the sequencer starts the next word only
// after the last one has been loaded into the result register.
// A queue of QUEUE_DEPTH words sits before the sequencer, and a result register
// after it, so input is accepted while a finished result waits. When the
// receiver stalls, the result holds and the sequencer stops at its last step.
// Reset clears level, stage, pending trigger, queue and output valid, and
// loads the register defaults.
module cycling_slew_envelope_unit import csenv_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] target_level
	input  logic [0:0]  s_tuser,    // [0] trigger
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] cv_out
	output logic [1:0]  m_tuser,    // [0] end_of_rise, [1] end_of_cycle
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	item_t   push_item;
	item_t   head;
	logic    push;
	logic    pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise       <= 17'd1426;
			cfg_q.fall       <= 17'd1426;
			cfg_q.depth      <= DEP_ONE;
			cfg_q.cycle_mode <= 1'b0;
			cfg_q.frozen     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RISE:  cfg_q.rise  <= (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;
				CFG_FALL:  cfg_q.fall  <= (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;
				CFG_DEPTH: begin
					cfg_q.depth <= (cfg_data[DEP_W-1:0] > DEP_ONE) ? DEP_ONE
					                                                : cfg_data[DEP_W-1:0];
				end
				CFG_CYCLE: cfg_q.cycle_mode <= cfg_data[0];
				CFG_FROZE: cfg_q.frozen     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	csenv_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	csenv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	csenv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: tb/envelope_checker.sv
// Checker for the cycling slew envelope unit: tracks registers, predicts each result word, compares.
module envelope_checker import csenv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic signed [LVL_W-1:0] cv;
		logic                    rise_end;
		logic                    cycle_end;
	} env_result_t;

	env_result_t             cv_expected[$];
	cfg_t                    regs;
	logic signed [LVL_W-1:0] level;
	phase_t                  stage;
	logic                    trig_held;
	int                      nfail;

	// One-pole step toward goal; the step is rounded up so any nonzero k moves.
	function automatic logic signed [LVL_W-1:0] lag_toward(int cur, int goal, int k);
		longint diff, mag, step;
		diff = goal - cur;
		mag  = (diff < 0) ? -diff : diff;
		step = (mag * k + 65535) >> 16;
		if (step > mag)
			step = mag;
		return (diff < 0) ? LVL_W'(cur - step) : LVL_W'(cur + step);
	endfunction

	// level * depth / 16384, halves rounded away from zero
	function automatic logic signed [LVL_W-1:0] scaled_cv(logic signed [LVL_W-1:0] lv,
			logic [DEP_W-1:0] d);
		longint p, mag, r;
		p   = longint'(lv) * longint'(d);
		mag = (p < 0) ? -p : p;
		r   = (mag + 8192) >> 14;
		return (p < 0) ? LVL_W'(-r) : LVL_W'(r);
	endfunction

	function automatic env_result_t advance_envelope(logic [15:0] raw, logic trig);
		int          tgt;
		env_result_t res;
		tgt = int'($signed(raw));
		if (tgt > LVL_ONE)
			tgt = LVL_ONE;
		if (tgt < LVL_MONE)
			tgt = LVL_MONE;
		res = '0;
		if (trig)
			trig_held = 1'b1;
		if (!regs.frozen) begin
			if (trig_held) begin
				trig_held = 1'b0;
				level     = LVL_MONE;
				stage     = PH_RISE;
			end
			if (regs.cycle_mode && stage == PH_IDLE)
				stage = PH_RISE;
			case (stage)
				PH_IDLE: begin
					level = lag_toward(level, tgt, (tgt >= level) ? regs.rise : regs.fall);
				end
				PH_RISE: begin
					level = lag_toward(level, LVL_ONE, regs.rise);
					if (level >= SNAP_HI) begin
						level        = LVL_ONE;
						res.rise_end = 1'b1;
						stage        = PH_FALL;
					end
				end
				default: begin
					level = lag_toward(level, LVL_MONE, regs.fall);
					if (level <= SNAP_LO) begin
						level         = LVL_MONE;
						res.cycle_end = 1'b1;
						stage         = PH_IDLE;
					end
				end
			endcase
		end
		res.cv = scaled_cv(level, regs.depth);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		nfail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		env_result_t want;
		if (!arst_n) begin
			regs.rise       = 17'd1426;
			regs.fall       = 17'd1426;
			regs.depth      = DEP_ONE;
			regs.cycle_mode = 1'b0;
			regs.frozen     = 1'b0;
			level           = '0;
			stage           = PH_IDLE;
			trig_held       = 1'b0;
			nfail           = 0;
			cv_expected.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			// take the output word first so a same-edge input cannot pair with it
			if (m_tvalid && m_tready) begin
				if (cv_expected.size() == 0) begin
					report_mismatch("word with nothing expected, cv_out", $signed(m_tdata), 0);
				end else begin
					want = cv_expected.pop_front();
					if ($signed(m_tdata) != want.cv)
						report_mismatch("cv_out", $signed(m_tdata), want.cv);
					if (m_tuser[0] != want.rise_end)
						report_mismatch("end_of_rise", m_tuser[0], want.rise_end);
					if (m_tuser[1] != want.cycle_end)
						report_mismatch("end_of_cycle", m_tuser[1], want.cycle_end);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RISE:  regs.rise = (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;
					CFG_FALL:  regs.fall = (cfg_data > COEF_ONE) ? COEF_ONE : cfg_data;
					CFG_DEPTH: regs.depth = (cfg_data[DEP_W-1:0] > DEP_ONE) ?
							DEP_ONE : cfg_data[DEP_W-1:0];
					CFG_CYCLE: regs.cycle_mode = cfg_data[0];
					CFG_FROZE: regs.frozen = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				cv_expected.push_back(advance_envelope(s_tdata, s_tuser[0]));
			fails   <= nfail;
			pending <= cv_expected.size();
		end
	end

endmodule

FILE: tb/tb_cycling_slew_envelope_unit.sv
// Testbench top for the cycling slew envelope unit: clock, reset, stimulus and verdict.
module tb_cycling_slew_envelope_unit;
	import csenv_pkg::*;

	localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;     // [15:0] target_level
	logic [0:0]  s_tuser;     // [0] trigger
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;     // [15:0] cv_out
	logic [1:0]  m_tuser;     // [0] end_of_rise, [1] end_of_cycle
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;
	int          fails;
	int          pending;
	bit          steady;

	cycling_slew_envelope_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	envelope_checker env_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 1500000);
		$display("** cycling_slew_envelope_unit: FAILED **");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [16:0] pick_coeff();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 17'd0;
		if (r == 1)
			return 17'd1;
		if (r < 4)
			return COEF_ONE;
		if (r == 4)
			return 17'($urandom_range(65537, 131071));
		return 17'($urandom_range(4000, 65535));
	endfunction

	function automatic logic [16:0] pick_depth();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 17'd0;
		if (r < 3)
			return 17'(DEP_ONE);
		if (r == 3)
			return 17'($urandom_range(16385, 131071));
		return 17'($urandom_range(1, 16383));
	endfunction

	function automatic logic [15:0] pick_target();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom());
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	task automatic send_tick(logic [15:0] tgt, logic trig);
		int gap;
		s_tdata  <= tgt;
		s_tuser  <= trig;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(logic [16:0] rise, logic [16:0] fall, logic [16:0] dep,
			logic cyc, logic frz);
		write_reg(CFG_RISE, rise);
		write_reg(CFG_FALL, fall);
		write_reg(CFG_DEPTH, dep);
		write_reg(CFG_CYCLE, 17'(cyc));
		write_reg(CFG_FROZE, 17'(frz));
		write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 17'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// hold off until every word sent so far has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver: random stalls, plus one long hold to back up the input queue
	initial begin
		int got;
		int stall;
		got = 0;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got++;
			stall = (got == 60) ? 400 : idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		int wait_cnt;
		steady    = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: target extremes and out-of-range targets
		send_tick(16'sd16384, 1'b0);
		send_tick(-16'sd16384, 1'b0);
		send_tick(16'h7FFF, 1'b0);
		send_tick(16'h8000, 1'b0);
		send_tick(16'h4001, 1'b0);
		send_tick(16'hBFFF, 1'b0);
		send_tick(16'h0000, 1'b0);
		send_tick(16'h0001, 1'b0);
		drain();

		// over-range register values saturate; full-speed rise and fall end at once
		load_regs(17'h1FFFF, COEF_ONE, 17'h1FFFF, 1'b0, 1'b0);
		send_tick(16'h0000, 1'b1);
		send_tick(16'h0000, 1'b0);
		send_tick(16'h2001, 1'b0);
		drain();

		// frozen: level held, trigger kept pending; odd level at half depth rounds up
		load_regs(17'd1, 17'd1, 17'd8192, 1'b0, 1'b1);
		send_tick(16'h1234, 1'b1);
		drain();

		// unfreeze in cycle mode: pending trigger fires, the rise ends at once and the level then falls
		load_regs(COEF_ONE, 17'd30000, 17'(DEP_ONE), 1'b1, 1'b0);
		repeat (4) send_tick(pick_target(), 1'b0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			steady = (ph == 4);
			load_regs(ph == 1 ? 17'd1 : pick_coeff(), pick_coeff(),
					ph == 0 ? 17'd0 : pick_depth(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 5) == 0);
			repeat (60) send_tick(pick_target(), $urandom_range(0, 11) == 0);
			if (ph < 7)
				drain();
		end

		steady = 1'b0;
		s_tvalid <= 1'b0;
		for (wait_cnt = 0; wait_cnt < 20000 && pending != 0; wait_cnt++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("** cycling_slew_envelope_unit: PASSED **");
		else
			$display("** cycling_slew_envelope_unit: FAILED **");
		$finish;
	end

endmodule
